>>> sv/assert_macros.svh
// assertion macros used by the entry queue of the base64 decoder rtl
// every macro expects clk and rst (synchronous, active high) in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(name, cond, msg) \
  `ASSERT_AT(name, !(cond), msg)

`endif

>>> sv/b64d_pkg.sv
// shared types, constants and the character classifier of the base64 decoder
// no dependencies
`default_nettype none

package b64d_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int BYTES_MAX   = 3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // bytes of one input item, oldest in bytes[0]; cnt is 1 to 3
  typedef struct packed {
    logic [BYTES_MAX-1:0][7:0] bytes;
    logic [1:0]                cnt;
  } entry_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t    s;
    logic [7:0] d;
    s = '{ok: 1'b0, val: 6'd0};
    d = 8'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
      s = '{ok: 1'b1, val: d[5:0]};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A;
      s = '{ok: 1'b1, val: d[5:0] + SEXTET_LOWER_BASE};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d = c - CHAR_DIGIT_0;
      s = '{ok: 1'b1, val: d[5:0] + SEXTET_DIGIT_BASE};
    end else if (c == CHAR_PLUS) begin
      s = '{ok: 1'b1, val: SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      s = '{ok: 1'b1, val: SEXTET_SLASH};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> sv/b64d_front.sv
// front end: accepts characters, keeps the sextet group state, builds byte entries
// depends on b64d_pkg
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       string_end,
  output logic            push,
  output entry_t          push_entry
);

  logic [17:0] sextet_buffer, sextet_buffer_next;
  logic [1:0]  group_count, group_count_next;
  logic        halted, halted_next;

  sextet_t     sx;
  logic        accept;
  logic [23:0] word;
  logic [17:0] nb;
  logic [1:0]  nc;
  logic        flush;

  assign accept = in_valid && in_ready;
  assign sx     = sextet_of(char_code);
  assign word   = {sextet_buffer, sx.val};

  always_comb begin
    nb    = sx.ok ? {sextet_buffer[11:0], sx.val} : sextet_buffer;
    nc    = sx.ok ? group_count + 2'd1 : group_count;
    flush = !sx.ok || string_end;

    push_entry = '{bytes: '0, cnt: 2'd0};
    sextet_buffer_next = sextet_buffer;
    group_count_next   = group_count;
    halted_next        = halted;

    if (!halted) begin
      if (sx.ok && group_count == 2'd3) begin
        push_entry.bytes[0] = word[23:16];
        push_entry.bytes[1] = word[15:8];
        push_entry.bytes[2] = word[7:0];
        push_entry.cnt      = 2'd3;
        sextet_buffer_next  = '0;
        group_count_next    = 2'd0;
      end else begin
        // partial group flush on a stop character or end of string
        if (flush && nc == 2'd2) begin
          push_entry.bytes[0] = nb[11:4];
          push_entry.cnt      = 2'd1;
        end else if (flush && nc == 2'd3) begin
          push_entry.bytes[0] = nb[17:10];
          push_entry.bytes[1] = nb[9:2];
          push_entry.cnt      = 2'd2;
        end
        if (sx.ok) begin
          sextet_buffer_next = nb;
          group_count_next   = nc;
        end else begin
          sextet_buffer_next = '0;
          group_count_next   = 2'd0;
          halted_next        = 1'b1;
        end
      end
    end

    if (string_end) begin
      sextet_buffer_next = '0;
      group_count_next   = 2'd0;
      halted_next        = 1'b0;
    end
  end

  assign push = accept && (push_entry.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_buffer <= '0;
      group_count   <= 2'd0;
      halted        <= 1'b0;
    end else if (accept) begin
      sextet_buffer <= sextet_buffer_next;
      group_count   <= group_count_next;
      halted        <= halted_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/b64d_queue.sv
// small entry queue between the front end and the byte serializer
// depends on b64d_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        not_full,
  output logic        not_empty,
  output entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_push_full, push && !not_full, "entry pushed into a full queue")
  `ASSERT_NEVER(a_pop_empty, pop && !not_empty, "entry popped from an empty queue")
  `ASSERT_AT(a_entry_cnt, !not_empty || head.cnt != 2'd0, "queued entry carries no bytes")
  `ASSERT_AT(a_count_step, (push && !pop) |=> count == $past(count) + 1'b1,
             "queue count did not follow a push")

endmodule

`default_nettype wire

>>> sv/b64d_back.sv
// back end: sends the bytes of the head queue entry one per transfer
// depends on b64d_pkg
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       not_empty,
  input  wire entry_t     head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      data_byte,
  output logic            run_last
);

  logic [1:0] idx;

  assign out_valid = not_empty;
  assign data_byte = head.bytes[idx];
  assign run_last  = (idx == head.cnt - 2'd1);
  assign pop       = out_valid && out_ready && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= run_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> sv/base64_decoder.sv
// base64 decoder top level: front end, entry queue and byte serializer
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
//
// input channel: one ascii character per transfer (char_code), with
// string_end set on the last character of a string. output channel: one
// decoded byte per transfer (data_byte), with run_last set on the last byte
// that a given character produced. characters that produce no byte give no
// output transfer.
// the first byte of a character is offered once its entry has been written
// into the queue and reached its head. throughput: one character per cycle
// while the entry queue has room; the serializer sends one byte per cycle
// while out_ready is high, so a full group's three bytes keep up with its four characters.
// in_ready drops only when all DEPTH queue entries hold bytes; when the
// receiver stalls, the head byte holds until taken and characters keep
// flowing until the queue fills.
// reset clears the group state, the halt flag and the queue.
`default_nettype none

module base64_decoder
  import b64d_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       string_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      data_byte,
  output logic            run_last
);

  logic   push;
  logic   pop;
  logic   not_full;
  logic   not_empty;
  entry_t push_entry;
  entry_t head;

  assign in_ready = not_full;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .string_end (string_end),
    .push       (push),
    .push_entry (push_entry)
  );

  b64d_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .not_full   (not_full),
    .not_empty  (not_empty),
    .head       (head)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_byte (data_byte),
    .run_last  (run_last)
  );

endmodule

`default_nettype wire

>>> sim/base64_decoder_test.sv
// testbench for base64_decoder: directed character table, then random strings
// checked byte by byte against a local decoder model; depends on base64_decoder only
`timescale 1ns / 1ps

module base64_decoder_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 8;

  // one decoded byte that the block must still deliver
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } out_byte_t;

  // directed stimulus; bytes[0] is the first byte out
  typedef struct packed {
    logic [7:0]      ch;
    logic            fin;
    logic            typed;
    logic [1:0]      n;
    logic [0:2][7:0] bytes;
  } char_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       string_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] data_byte;
  logic       run_last;

  // decoder model state
  logic [17:0] dec_bits;
  logic [1:0]  dec_cnt;
  logic        dec_halted;

  out_byte_t pending_bytes[$];
  int        fail_count;
  int        chars_counted;
  int        cycle_count;
  int        send_idle;
  int        recv_idle;
  int        stall_req;
  int        stall_ack;
  int        hold_left;

  char_row_t char_rows [0:24];

  base64_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .string_end(string_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_byte (data_byte),
    .run_last  (run_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit sextet_value(input logic [7:0] c, output logic [5:0] v);
    logic [7:0] d;
    d = 8'd0;
    v = 6'd0;
    if (c >= "A" && c <= "Z") d = c - "A";
    else if (c >= "a" && c <= "z") d = c - "a" + 8'd26;
    else if (c >= "0" && c <= "9") d = c - "0" + 8'd52;
    else if (c == "+") d = 8'd62;
    else if (c == "/") d = 8'd63;
    else return 1'b0;
    v = d[5:0];
    return 1'b1;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return "A" + v;
    if (v < 6'd52) return "a" + (v - 6'd26);
    if (v < 6'd62) return "0" + (v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  // partial group: missing sextets count as zero
  function automatic void flush_partial(inout int n, inout logic [0:2][7:0] b);
    if (dec_cnt == 2'd2) begin
      b[n] = dec_bits[11:4];
      n = n + 1;
    end else if (dec_cnt == 2'd3) begin
      b[n] = dec_bits[17:10];
      b[n+1] = dec_bits[9:2];
      n = n + 2;
    end
    dec_bits = 18'd0;
    dec_cnt = 2'd0;
  endfunction

  function automatic void decode_char(input logic [7:0] ch, input logic fin,
                                      output int n, output logic [0:2][7:0] b);
    logic [5:0]  v;
    logic [23:0] word;
    n = 0;
    b = '0;
    if (!dec_halted) begin
      if (sextet_value(ch, v)) begin
        if (dec_cnt == 2'd3) begin
          word = {dec_bits, v};
          b = word;
          n = 3;
          dec_bits = 18'd0;
          dec_cnt = 2'd0;
        end else begin
          dec_bits = {dec_bits[11:0], v};
          dec_cnt = dec_cnt + 2'd1;
        end
      end else begin
        flush_partial(n, b);
        dec_halted = 1'b1;
      end
    end
    if (fin) begin
      flush_partial(n, b);
      dec_halted = 1'b0;
    end
  endfunction

  // offer one character, wait for its transfer, then maybe idle
  task automatic put_char(input logic [7:0] ch, input logic fin, input logic typed = 1'b0,
                          input int t_n = 0, input logic [0:2][7:0] t_b = '0);
    int              n;
    logic [0:2][7:0] b;
    in_valid <= 1'b1;
    char_code <= ch;
    string_end <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_counted++;
    decode_char(ch, fin, n, b);
    if (typed) begin
      n = t_n;
      b = t_b;
    end
    for (int i = 0; i < n; i++) pending_bytes.push_back('{data: b[i], fin: (i == n - 1)});
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  // mostly well-formed strings, some with a bad character, some pure noise,
  // some left open so the group carries into the next string
  task automatic send_string();
    logic [7:0] chars[$];
    int         kind;
    int         len;
    int         bad_at;
    kind = $urandom_range(0, 9);
    len = $urandom_range(1, 14);
    bad_at = (kind == 7) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (kind == 8 || i == bad_at) chars.push_back(8'($urandom_range(0, 255)));
      else chars.push_back(sextet_char(6'($urandom_range(0, 63))));
    end
    if (kind < 5 && (len % 4) >= 2) repeat (4 - len % 4) chars.push_back("=");
    foreach (chars[i]) put_char(chars[i], (kind != 9) && (i == chars.size() - 1));
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (stall_req != stall_ack) begin
      stall_ack = stall_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : check_byte
    out_byte_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected transfer data_byte %h run_last %b",
                 $time, data_byte, run_last);
        fail_count++;
      end else begin
        e = pending_bytes.pop_front();
        if (data_byte !== e.data) begin
          $display("%0t: data_byte expected %h actual %h", $time, e.data, data_byte);
          fail_count++;
        end
        if (run_last !== e.fin) begin
          $display("%0t: run_last expected %b actual %b", $time, e.fin, run_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes outstanding", $time, pending_bytes.size());
      $display("base64_decoder_test: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = 8'd0;
    string_end = 1'b0;
    dec_bits = 18'd0;
    dec_cnt = 2'd0;
    dec_halted = 1'b0;
    fail_count = 0;
    chars_counted = 0;
    cycle_count = 0;
    stall_req = 0;
    stall_ack = 0;
    send_idle = 28;
    recv_idle = 73;
    // ch, string_end, typed, byte count, bytes
    char_rows = '{
      {"T",   1'b0, 1'b1, 2'd0, 24'h000000},  // nothing after reset
      {"W",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"F",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"u",   1'b0, 1'b1, 2'd3, 24'h4d616e},
      {"/",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"/",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"/",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"/",   1'b0, 1'b1, 2'd3, 24'hffffff},
      {"A",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"A",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"A",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"A",   1'b1, 1'b1, 2'd3, 24'h000000},  // full group and end together
      {"Q",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"Q",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"=",   1'b0, 1'b1, 2'd1, 24'h410000},  // pad flushes two sextets
      {"z",   1'b0, 1'b1, 2'd0, 24'h000000},  // ignored while halted
      {8'hff, 1'b1, 1'b1, 2'd0, 24'h000000},  // end while halted resumes
      {"+",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"9",   1'b0, 1'b0, 2'd0, 24'h000000},
      {"a",   1'b1, 1'b0, 2'd0, 24'h000000},  // end flushes three sextets
      {8'h80, 1'b0, 1'b1, 2'd0, 24'h000000},
      {"B",   1'b1, 1'b1, 2'd0, 24'h000000},
      {"g",   1'b1, 1'b1, 2'd0, 24'h000000},  // lone sextet gives nothing
      {8'h00, 1'b0, 1'b1, 2'd0, 24'h000000},
      {8'h7f, 1'b1, 1'b1, 2'd0, 24'h000000}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (char_rows[i])
      put_char(char_rows[i].ch, char_rows[i].fin, char_rows[i].typed,
               char_rows[i].n, char_rows[i].bytes);
    while (chars_counted < 70) send_string();

    // long receiver hold-off while characters keep coming; more full groups
    // than queue entries so the input stalls
    stall_req <= stall_req + 1;
    send_idle = 0;
    for (int i = 0; i < 20; i++) put_char(sextet_char(6'($urandom_range(0, 63))), i == 19);
    in_valid <= 1'b0;
    wait_drained();

    send_idle = 73;
    recv_idle = 28;
    while (chars_counted < 140) send_string();
    send_idle = 0;
    recv_idle = 0;
    while (chars_counted < 215) send_string();
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("base64_decoder_test: PASS");
    end else begin
      $display("base64_decoder_test: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_decoder.sv
sim/base64_decoder_test.sv
